// ===== sv/tilt_moving_average_classifier_defines.svh =====
// Assertion macros used by the tilt classifier checker.
// No dependencies; include by bare file name.
`ifndef TILT_MOVING_AVERAGE_CLASSIFIER_DEFINES_SVH
`define TILT_MOVING_AVERAGE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define TMAC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tmac assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define TMAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tmac assertion failed");

`endif

// ===== sv/tmac_pkg.sv =====
// Shared types and constants for the tilt moving-average classifier.
// No dependencies.
package tmac_pkg;

  // Dead-zone threshold registers
  localparam int unsigned THRESH_BITS  = 15;
  localparam int unsigned CFG_IDX_BITS = 1;

  typedef logic [THRESH_BITS-1:0]  thresh_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_STEER_THR = 1'd0;
  localparam cfg_idx_t REG_DRIVE_THR = 1'd1;

  localparam thresh_t STEER_THR_RESET = 15'd41;
  localparam thresh_t DRIVE_THR_RESET = 15'd60;

  // Three-way class codes, two's complement -1 / 0 / +1
  typedef logic [1:0] class_t;

  localparam class_t CLASS_NEG  = 2'b11;
  localparam class_t CLASS_ZERO = 2'b00;
  localparam class_t CLASS_POS  = 2'b01;

  // Mirror a class code (used for the inverted drive axis)
  function automatic class_t class_negate(input class_t c);
    class_t r;
    case (c)
      CLASS_NEG: r = CLASS_POS;
      CLASS_POS: r = CLASS_NEG;
      default:   r = CLASS_ZERO;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/tmac_cell.sv =====
// One delay cell of the sample history chain: holds one x and one y sample.
// Depends on nothing; instantiated WINDOW_DEPTH times by the top level.
module tmac_cell #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          shift_i,
  input  logic signed [SAMPLE_BITS-1:0] x_i,
  input  logic signed [SAMPLE_BITS-1:0] y_i,
  output logic signed [SAMPLE_BITS-1:0] x_o,
  output logic signed [SAMPLE_BITS-1:0] y_o
);

  logic signed [SAMPLE_BITS-1:0] x_q, y_q;

  // History starts all zero; advance one place per request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else if (shift_i) begin
      x_q <= x_i;
      y_q <= y_i;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

// ===== sv/tmac_axis.sv =====
// Running window sum for one axis, with shift, saturation and dead-zone class.
// Depends on tmac_pkg.
module tmac_axis #(
  parameter int unsigned WINDOW_DEPTH = 64,
  parameter int unsigned SAMPLE_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          advance_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] oldest_i,
  input  tmac_pkg::thresh_t             thresh_i,
  output logic signed [SAMPLE_BITS-1:0] filtered_o,
  output tmac_pkg::class_t              class_o
);

  import tmac_pkg::*;

  localparam int unsigned SUM_BITS = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  // floor(log2(depth))
  localparam int unsigned SHIFT    = $clog2(WINDOW_DEPTH + 1) - 1;
  localparam int unsigned CMP_BITS =
    ((SAMPLE_BITS > THRESH_BITS + 1) ? SAMPLE_BITS : THRESH_BITS + 1) + 1;

  localparam logic signed [SUM_BITS-1:0] SAT_HI =
    {{(SUM_BITS - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SAT_LO = ~SAT_HI;

  logic signed [SUM_BITS-1:0] sum_d, sum_q;
  logic signed [SUM_BITS-1:0] shifted;
  logic signed [SUM_BITS-1:0] clamped;
  logic signed [CMP_BITS-1:0] val_ext, thr_pos, thr_neg;

  // Drop the sample leaving the window, add the new one
  assign sum_d = sum_q - SUM_BITS'(oldest_i) + SUM_BITS'(sample_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (advance_i) begin
      sum_q <= sum_d;
    end
  end

  // Average by arithmetic shift; clamp only matters for depths that are not a power of two
  always_comb begin
    shifted = sum_q >>> SHIFT;
    if (shifted > SAT_HI) begin
      clamped = SAT_HI;
    end else if (shifted < SAT_LO) begin
      clamped = SAT_LO;
    end else begin
      clamped = shifted;
    end
  end

  assign filtered_o = clamped[SAMPLE_BITS-1:0];

  // Symmetric dead zone around zero
  assign val_ext = CMP_BITS'(filtered_o);
  assign thr_pos = signed'(CMP_BITS'(thresh_i));
  assign thr_neg = -thr_pos;

  always_comb begin
    if (val_ext < thr_neg) begin
      class_o = CLASS_NEG;
    end else if (val_ext > thr_pos) begin
      class_o = CLASS_POS;
    end else begin
      class_o = CLASS_ZERO;
    end
  end

endmodule

// ===== sv/tilt_moving_average_classifier.sv =====
// Tilt moving-average classifier: x/y sample history chain, sums, output stage.
// Depends on tmac_pkg, tmac_cell and tmac_axis.
//
// Usage: one request on the input channel (in_valid_i / in_stall_o) carries an
// x and a y sample. For each request one result leaves on the output channel
// (out_valid_o / out_stall_i): the moving averages of the last WINDOW_DEPTH
// samples of each axis, a steer class for x and an inverted drive class for y.
// The running sums update at input acceptance and the averages and classes are
// registered into the output register when it is free; a stalled receiver
// delays that load. Throughput is one request per cycle while the receiver
// does not stall; the sum update of each axis is one add and subtract, and the
// history chain shifts one cell per request. When the receiver stalls, the
// held result stays put and one more request is still taken into the sum
// stage; the input stalls only while both are full. Reset empties both stages,
// zeroes the history and the sums, and loads the thresholds with 41 (steer) and
// 60 (drive). Thresholds are written through cfg_we_i / cfg_idx_i / cfg_wdata_i;
// the user writes only while no request is in flight; not enforced by the block.
module tilt_moving_average_classifier #(
  parameter int unsigned WINDOW_DEPTH = 64,
  parameter int unsigned SAMPLE_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  tmac_pkg::cfg_idx_t            cfg_idx_i,
  input  tmac_pkg::thresh_t             cfg_wdata_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_x_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_y_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] filtered_x_o,
  output logic signed [SAMPLE_BITS-1:0] filtered_y_o,
  output tmac_pkg::class_t              steer_o,
  output tmac_pkg::class_t              drive_o
);

  import tmac_pkg::*;

  thresh_t steer_thr_q, drive_thr_q;

  logic in_accept;
  logic sum_valid_d, sum_valid_q;
  logic out_valid_d, out_valid_q;
  logic out_load;

  logic signed [SAMPLE_BITS-1:0] tap_x [0:WINDOW_DEPTH];
  logic signed [SAMPLE_BITS-1:0] tap_y [0:WINDOW_DEPTH];

  logic signed [SAMPLE_BITS-1:0] avg_x, avg_y;
  class_t                        cls_x, cls_y;

  logic signed [SAMPLE_BITS-1:0] filt_x_q, filt_y_q;
  class_t                        steer_q, drive_q;

  // Threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steer_thr_q <= STEER_THR_RESET;
      drive_thr_q <= DRIVE_THR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STEER_THR: steer_thr_q <= cfg_wdata_i;
        REG_DRIVE_THR: drive_thr_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Two-stage handshake: sum stage feeds the output register
  assign out_load    = sum_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = sum_valid_q && !out_load;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign sum_valid_d = in_accept || (sum_valid_q && !out_load);
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sum_valid_q <= sum_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Sample history: cell 0 takes the new sample, the last cell is the oldest
  assign tap_x[0] = sample_x_i;
  assign tap_y[0] = sample_y_i;

  for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
    tmac_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(in_accept),
      .x_i    (tap_x[g]),
      .y_i    (tap_y[g]),
      .x_o    (tap_x[g+1]),
      .y_o    (tap_y[g+1])
    );
  end

  // Per-axis running sums and classes
  tmac_axis #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_axis_x (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (in_accept),
    .sample_i  (sample_x_i),
    .oldest_i  (tap_x[WINDOW_DEPTH]),
    .thresh_i  (steer_thr_q),
    .filtered_o(avg_x),
    .class_o   (cls_x)
  );

  tmac_axis #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_axis_y (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (in_accept),
    .sample_i  (sample_y_i),
    .oldest_i  (tap_y[WINDOW_DEPTH]),
    .thresh_i  (drive_thr_q),
    .filtered_o(avg_y),
    .class_o   (cls_y)
  );

  // Output register; drive is mirrored so forward tilt drives ahead
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      filt_x_q <= avg_x;
      filt_y_q <= avg_y;
      steer_q  <= cls_x;
      drive_q  <= class_negate(cls_y);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign filtered_x_o = filt_x_q;
  assign filtered_y_o = filt_y_q;
  assign steer_o      = steer_q;
  assign drive_o      = drive_q;

endmodule

// ===== sv/tmac_checker.sv =====
// Port-level checker for the tilt classifier, bound to the top level.
// Depends on tmac_pkg and tilt_moving_average_classifier_defines.svh.
`include "tilt_moving_average_classifier_defines.svh"

module tmac_checker #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [SAMPLE_BITS-1:0] filtered_x_o,
  input logic signed [SAMPLE_BITS-1:0] filtered_y_o,
  input tmac_pkg::class_t              steer_o,
  input tmac_pkg::class_t              drive_o
);

  import tmac_pkg::*;

  // A stalled result keeps its valid
  `TMAC_ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // A stalled result keeps its payload
  `TMAC_ASSERT_NEXT(a_out_data_hold, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(filtered_x_o) && $stable(filtered_y_o) && $stable(steer_o) && $stable(drive_o))

  // Input only backs up when a result is held by the receiver
  `TMAC_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // Positive steer needs a positive x average
  `TMAC_ASSERT_IMPL(a_steer_sign, clk_i, rst_ni, out_valid_o && steer_o == CLASS_POS, !filtered_x_o[SAMPLE_BITS-1] && filtered_x_o != '0)

  // Drive is inverted: positive drive needs a negative y average
  `TMAC_ASSERT_IMPL(a_drive_sign, clk_i, rst_ni, out_valid_o && drive_o == CLASS_POS, filtered_y_o[SAMPLE_BITS-1])

endmodule

bind tilt_moving_average_classifier tmac_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_tmac_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .filtered_x_o(filtered_x_o),
  .filtered_y_o(filtered_y_o),
  .steer_o     (steer_o),
  .drive_o     (drive_o)
);
